// ===== hw/rtl/srrb_pkg.sv =====
// Shared constants, field widths and pointer helpers for the serial receive ring.
package srrb_pkg;

  // Ring geometry; one slot always stays empty.
  localparam int RING_DEPTH     = 4096;
  localparam int MAX_READ_BURST = 64;
  localparam int PTR_W          = $clog2(RING_DEPTH);

  // Field widths of the stream payloads.
  localparam int BYTE_W       = 8;
  localparam int READ_MAX_W   = 7;
  localparam int KIND_W       = 2;
  localparam int DROP_W       = 32;
  localparam int FILL_W       = 12;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_PAD_W    = OUT_TDATA_W - (BYTE_W + 1 + DROP_W + FILL_W);

  // Width used to compare a burst length against the ring occupancy.
  localparam int CMP_W = (PTR_W > READ_MAX_W) ? PTR_W : READ_MAX_W;

  // Request kinds on the input side.
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // Result kinds on the output side.
  localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

  // Step a pointer by one slot, wrapping after the last slot.
  function automatic ptr_t ptr_advance(input ptr_t p);
    ptr_t n;
    n = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  // Number of bytes held between the read and write pointers.
  function automatic ptr_t ring_fill(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] diff;
    diff = {1'b0, wp} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, rp};
    if (diff >= (PTR_W + 1)'(RING_DEPTH)) begin
      diff = diff - (PTR_W + 1)'(RING_DEPTH);
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/srrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module srrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/serial_rx_ring_buffer.sv =====
// Serial receive ring: byte arrivals, burst reads and a wrapping drop counter.
//
//   channel   | direction | tdata                                    | tuser        | tlast
//   ----------+-----------+------------------------------------------+--------------+-------
//   s_axis    | in        | rx_byte, line_overrun, read_max          | req_type     | -
//   m_axis    | out       | data_byte, byte_stored, drop_total,      | result_kind  | last
//             |           | fill_level, zero pad                     |              |
//
// An arrival yields one transaction. A read that finds bytes issues one ring RAM read per
// cycle and delivers one byte per cycle unless the output stalls; the RAM read is registered,
// so the first byte is read when the request is taken and delivered from the read state. A
// read that finds nothing yields one transaction. Reset clears the pointers, the drop counter
// and the output valid flag; the ring RAM needs no clearing. A stalled output holds the
// output register and pauses the burst; a new transaction is taken only between requests.
module serial_rx_ring_buffer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] rx_byte, [8] line_overrun, [15:9] read_max
  input  logic [srrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] data_byte, [8] byte_stored, [40:9] drop_total, [52:41] fill_level, [55:53] zero
  output logic [srrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] result_kind
  output logic [srrb_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                                state;
  srrb_pkg::ptr_t                      wp;
  srrb_pkg::ptr_t                      rp;
  logic [srrb_pkg::DROP_W-1:0]         drop_cnt;
  logic [srrb_pkg::READ_MAX_W-1:0]     remaining;

  // Output register.
  logic                                out_valid;
  logic [srrb_pkg::KIND_W-1:0]         out_kind;
  logic [srrb_pkg::BYTE_W-1:0]         out_byte;
  logic                                out_stored;
  logic [srrb_pkg::DROP_W-1:0]         out_drop;
  logic [srrb_pkg::FILL_W-1:0]         out_fill;
  logic                                out_last;

  logic                                out_free;
  logic                                in_accept;
  logic                                req_type;
  logic [srrb_pkg::BYTE_W-1:0]         rx_byte;
  logic                                line_overrun;
  logic [srrb_pkg::READ_MAX_W-1:0]     read_max;

  srrb_pkg::ptr_t                      wp_adv;
  srrb_pkg::ptr_t                      rp_adv;
  logic                                ring_full;
  srrb_pkg::ptr_t                      fill_now;
  srrb_pkg::ptr_t                      fill_after_wr;
  srrb_pkg::ptr_t                      fill_after_rd;
  logic [srrb_pkg::DROP_W-1:0]         drop_arr;
  logic [srrb_pkg::READ_MAX_W-1:0]     want;
  logic [srrb_pkg::READ_MAX_W-1:0]     burst_len;
  logic                                load_data;

  logic                                ram_we;
  logic                                ram_re;
  srrb_pkg::ptr_t                      ram_raddr;
  logic [srrb_pkg::BYTE_W-1:0]         ram_rdata;

  // Input field unpacking.
  assign req_type     = s_axis_tuser;
  assign rx_byte      = s_axis_tdata[7:0];
  assign line_overrun = s_axis_tdata[8];
  assign read_max     = s_axis_tdata[15:9];

  // Handshakes.
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_data     = (state == ST_READ) && out_free;

  // Pointer arithmetic and occupancy.
  assign wp_adv        = srrb_pkg::ptr_advance(wp);
  assign rp_adv        = srrb_pkg::ptr_advance(rp);
  assign ring_full     = (wp_adv == rp);
  assign fill_now      = srrb_pkg::ring_fill(wp, rp);
  assign fill_after_wr = ring_full ? fill_now : srrb_pkg::ring_fill(wp_adv, rp);
  assign fill_after_rd = srrb_pkg::ring_fill(wp, rp_adv);

  // Drop counter after an arrival: one for a full ring, one more for an overrun.
  assign drop_arr = drop_cnt + srrb_pkg::DROP_W'(ring_full)
                  + srrb_pkg::DROP_W'(line_overrun);

  // Burst length: the request cut to the burst limit, then to the bytes held.
  always_comb begin
    want = read_max;
    if (read_max > srrb_pkg::READ_MAX_W'(srrb_pkg::MAX_READ_BURST)) begin
      want = srrb_pkg::READ_MAX_W'(srrb_pkg::MAX_READ_BURST);
    end
    if (srrb_pkg::CMP_W'(want) < srrb_pkg::CMP_W'(fill_now)) begin
      burst_len = want;
    end else begin
      burst_len = srrb_pkg::READ_MAX_W'(fill_now);
    end
  end

  // Ring RAM control: writes on stored arrivals, reads one slot ahead of delivery.
  assign ram_we    = in_accept && (req_type == srrb_pkg::REQ_ARRIVAL) && !ring_full;
  assign ram_re    = (in_accept && (req_type == srrb_pkg::REQ_READ) && (burst_len != '0))
                   || (load_data && (remaining != srrb_pkg::READ_MAX_W'(1)));
  assign ram_raddr = (state == ST_READ) ? rp_adv : rp;

  srrb_ram #(
    .WIDTH (srrb_pkg::BYTE_W),
    .DEPTH (srrb_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state: pointers, drop counter, burst sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      drop_cnt  <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            out_valid <= 1'b1;
            if (req_type == srrb_pkg::REQ_ARRIVAL) begin
              drop_cnt <= drop_arr;
              if (!ring_full) begin
                wp <= wp_adv;
              end
            end else if (burst_len != '0) begin
              // The first byte is read now and delivered from the read state.
              out_valid <= 1'b0;
              remaining <= burst_len;
              state     <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (load_data) begin
            out_valid <= 1'b1;
            rp        <= rp_adv;
            remaining <= remaining - srrb_pkg::READ_MAX_W'(1);
            if (remaining == srrb_pkg::READ_MAX_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte <= '0;
      out_drop <= drop_cnt;
      out_last <= 1'b1;
      if (req_type == srrb_pkg::REQ_ARRIVAL) begin
        out_kind   <= srrb_pkg::KIND_ARRIVAL;
        out_stored <= !ring_full;
        out_drop   <= drop_arr;
        out_fill   <= srrb_pkg::FILL_W'(fill_after_wr);
      end else begin
        out_kind   <= srrb_pkg::KIND_EMPTY;
        out_stored <= 1'b0;
        out_fill   <= srrb_pkg::FILL_W'(fill_now);
      end
    end else if (load_data) begin
      out_kind   <= srrb_pkg::KIND_DATA;
      out_byte   <= ram_rdata;
      out_stored <= 1'b0;
      out_drop   <= drop_cnt;
      out_fill   <= srrb_pkg::FILL_W'(fill_after_rd);
      out_last   <= (remaining == srrb_pkg::READ_MAX_W'(1));
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{srrb_pkg::OUT_PAD_W{1'b0}}, out_fill, out_drop, out_stored,
                          out_byte};

endmodule
